// ===== rtl/ihdb_pkg.sv =====
// Shared types and constants for the 2x2 box downscaler.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ihdb_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int LINE_AW    = $clog2(LINE_DEPTH);
	localparam int COL_W      = $clog2(MAX_WIDTH);

	localparam int PIX_W  = 8;
	localparam int SUM_W  = PIX_W + 1;
	localparam int SRCW_W = 13;
	localparam int SRCH_W = 16;
	localparam int TGTW_W = 12;
	localparam int TGTH_W = 16;
	localparam int IDX_W  = 3;
	localparam int DATA_W = 16;

	localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
	localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
	localparam logic [IDX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
	localparam logic [IDX_W-1:0] REG_TARGET_HEIGHT = 3'd3;

	// which average a result takes
	typedef enum logic [1:0] {
		KIND_QUAD,
		KIND_VERT,
		KIND_HORZ,
		KIND_PASS
	} kind_t;

	typedef struct packed {
		logic [SRCW_W-1:0] source_width;
		logic [SRCH_W-1:0] source_height;
		logic [TGTW_W-1:0] target_width;
		logic [TGTH_W-1:0] target_height;
		logic              ok;
		logic              extra_col;
		logic              extra_row;
	} cfg_t;

	typedef struct packed {
		logic             err;
		kind_t            kind;
		logic [PIX_W-1:0] pixel;
		logic [PIX_W-1:0] held;
		logic             row_end;
		logic             frame_end;
	} s1_t;

endpackage

`default_nettype wire

// ===== rtl/image_half_downscale_box_unit.sv =====
// 2x2 box downscaler with rounding: top level.
// Depends on ihdb_pkg, ihdb_cfg, ihdb_line_mem, ihdb_front and ihdb_out.
//
// Takes one 8-bit source pixel per clock in raster order, unless the output
// stalls, and gives the image halved in each direction: one result per 2x2
// block, issued on the block's bottom-right pixel, plus rounded pair averages
// for an odd last column or row when the target size asks for them. A result
// passes through the input register, then the output register; items that
// cause no result only update the counters and the line store. The 2048 x 9
// line store takes one write and one read per cycle, so full throughput holds
// at any image size. It needs no clearing after reset. A bad size setting
// makes every pixel return one error item. Writing any size register restarts
// the frame; write only while no item is in flight.
`default_nettype none

module image_half_downscale_box_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ihdb_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [ihdb_pkg::DATA_W-1:0]   cfg_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ihdb_pkg::PIX_W-1:0]    pixel_in,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [ihdb_pkg::PIX_W-1:0]         pixel_out,
	output logic                               status,
	output logic                               row_end,
	output logic                               frame_end
);

	ihdb_pkg::cfg_t             cfg;
	ihdb_pkg::s1_t              s1;
	logic                       restart, take, s1_valid;
	logic                       mem_we, mem_re;
	logic [ihdb_pkg::LINE_AW-1:0] mem_addr;
	logic [ihdb_pkg::SUM_W-1:0] mem_wdata, mem_rdata;

	ihdb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.restart   (restart)
	);

	ihdb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_in  (pixel_in),
		.cfg       (cfg),
		.restart   (restart),
		.take      (take),
		.s1_valid  (s1_valid),
		.s1        (s1),
		.mem_we    (mem_we),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re)
	);

	ihdb_line_mem u_line (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_addr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_addr),
		.rdata (mem_rdata)
	);

	ihdb_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1_valid  (s1_valid),
		.s1        (s1),
		.line_rd   (mem_rdata),
		.take      (take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.status    (status),
		.row_end   (row_end),
		.frame_end (frame_end)
	);

`ifndef SYNTHESIS
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status) |-> (pixel_out == '0 && !row_end && !frame_end))
		else $error("error item carries pixel or flags");
	a_frame_on_row: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_end) |-> row_end)
		else $error("frame end without row end");
	a_cfg_always_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config port stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/ihdb_cfg.sv =====
// Configuration registers and dimension check for the downscaler.
// Depends on ihdb_pkg.
`default_nettype none

module ihdb_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [ihdb_pkg::IDX_W-1:0]    cfg_index,
	input  wire logic [ihdb_pkg::DATA_W-1:0]   cfg_data,
	output ihdb_pkg::cfg_t                     cfg,
	output logic                               restart
);

	logic [ihdb_pkg::SRCW_W-1:0] src_w_q;
	logic [ihdb_pkg::SRCH_W-1:0] src_h_q;
	logic [ihdb_pkg::TGTW_W-1:0] tgt_w_q;
	logic [ihdb_pkg::TGTH_W-1:0] tgt_h_q;
	logic                        hit;
	logic [ihdb_pkg::TGTW_W:0]   half_w;
	logic [ihdb_pkg::SRCH_W:0]   half_h;
	logic                        w_exact, w_plus;
	logic                        h_exact, h_plus;

	assign cfg_ready = 1'b1;

	always_comb begin
		unique case (cfg_index)
			ihdb_pkg::REG_SOURCE_WIDTH,
			ihdb_pkg::REG_SOURCE_HEIGHT,
			ihdb_pkg::REG_TARGET_WIDTH,
			ihdb_pkg::REG_TARGET_HEIGHT: hit = 1'b1;
			default:                     hit = 1'b0;
		endcase
	end

	assign restart = cfg_valid && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= ihdb_pkg::SRCW_W'(2);
			src_h_q <= ihdb_pkg::SRCH_W'(2);
			tgt_w_q <= ihdb_pkg::TGTW_W'(1);
			tgt_h_q <= ihdb_pkg::TGTH_W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ihdb_pkg::REG_SOURCE_WIDTH:  src_w_q <= cfg_data[ihdb_pkg::SRCW_W-1:0];
				ihdb_pkg::REG_SOURCE_HEIGHT: src_h_q <= cfg_data[ihdb_pkg::SRCH_W-1:0];
				ihdb_pkg::REG_TARGET_WIDTH:  tgt_w_q <= cfg_data[ihdb_pkg::TGTW_W-1:0];
				ihdb_pkg::REG_TARGET_HEIGHT: tgt_h_q <= cfg_data[ihdb_pkg::TGTH_W-1:0];
				default: ;
			endcase
		end
	end

	assign half_w  = {1'b0, src_w_q[ihdb_pkg::SRCW_W-1:1]};
	assign half_h  = {2'b0, src_h_q[ihdb_pkg::SRCH_W-1:1]};
	assign w_exact = ({1'b0, tgt_w_q} == half_w);
	assign w_plus  = src_w_q[0] && ({1'b0, tgt_w_q} == half_w + 13'd1);
	assign h_exact = ({1'b0, tgt_h_q} == half_h);
	assign h_plus  = src_h_q[0] && ({1'b0, tgt_h_q} == half_h + 17'd1);

	always_comb begin
		cfg.source_width  = src_w_q;
		cfg.source_height = src_h_q;
		cfg.target_width  = tgt_w_q;
		cfg.target_height = tgt_h_q;
		cfg.extra_col     = w_plus;
		cfg.extra_row     = h_plus;
		cfg.ok            = (src_w_q != '0) && (src_h_q != '0)
		                    && (src_w_q <= ihdb_pkg::SRCW_W'(ihdb_pkg::MAX_WIDTH))
		                    && (w_exact || w_plus) && (h_exact || h_plus);
	end

endmodule

`default_nettype wire

// ===== rtl/ihdb_line_mem.sv =====
// Line store of top-row pair sums: one write and one registered read per cycle.
// Depends on ihdb_pkg for depth and width.
`default_nettype none

module ihdb_line_mem (
	input  wire logic                           clk,
	input  wire logic                           we,
	input  wire logic [ihdb_pkg::LINE_AW-1:0]   waddr,
	input  wire logic [ihdb_pkg::SUM_W-1:0]     wdata,
	input  wire logic                           re,
	input  wire logic [ihdb_pkg::LINE_AW-1:0]   raddr,
	output logic      [ihdb_pkg::SUM_W-1:0]     rdata
);

	logic [ihdb_pkg::SUM_W-1:0] mem [ihdb_pkg::LINE_DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/ihdb_front.sv =====
// Input stage: raster counters, held pixel, line store writes and the s1 register.
// Depends on ihdb_pkg.
`default_nettype none

module ihdb_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [ihdb_pkg::PIX_W-1:0]    pixel_in,
	input  wire ihdb_pkg::cfg_t                cfg,
	input  wire logic                          restart,
	input  wire logic                          take,
	output logic                               s1_valid,
	output ihdb_pkg::s1_t                      s1,
	output logic                               mem_we,
	output logic [ihdb_pkg::LINE_AW-1:0]       mem_addr,
	output logic [ihdb_pkg::SUM_W-1:0]         mem_wdata,
	output logic                               mem_re
);

	logic [ihdb_pkg::COL_W-1:0]  col_q;
	logic [ihdb_pkg::SRCH_W-1:0] row_q;
	logic [ihdb_pkg::PIX_W-1:0]  held_q;
	logic                        s1_valid_s1;
	ihdb_pkg::s1_t               s1_s1;

	logic accept, last_col, last_row, paired, c_odd, r_odd;
	logic corner, emit, load;
	ihdb_pkg::s1_t nxt;

	assign in_ready = !s1_valid_s1 || take;
	assign accept   = in_valid && in_ready;

	assign c_odd    = col_q[0];
	assign r_odd    = row_q[0];
	assign last_col = ({1'b0, col_q} + 13'd1) >= cfg.source_width;
	assign last_row = ({1'b0, row_q} + 17'd1) >= {1'b0, cfg.source_height};
	assign paired   = row_q < {cfg.source_height[ihdb_pkg::SRCH_W-1:1], 1'b0};
	assign corner   = last_col && cfg.extra_col;

	always_comb begin
		if (paired)
			emit = r_odd && (c_odd || corner);
		else
			emit = cfg.extra_row && (c_odd || corner);
	end

	always_comb begin
		nxt.err       = !cfg.ok;
		nxt.pixel     = pixel_in;
		nxt.held      = held_q;
		nxt.row_end   = ({1'b0, col_q[ihdb_pkg::COL_W-1:1]} + 12'd1) == cfg.target_width;
		nxt.frame_end = nxt.row_end
		                && (({1'b0, row_q[ihdb_pkg::SRCH_W-1:1]} + 16'd1) == cfg.target_height);
		if (paired)
			nxt.kind = c_odd ? ihdb_pkg::KIND_QUAD : ihdb_pkg::KIND_VERT;
		else
			nxt.kind = c_odd ? ihdb_pkg::KIND_HORZ : ihdb_pkg::KIND_PASS;
		if (!cfg.ok) begin
			nxt.row_end   = 1'b0;
			nxt.frame_end = 1'b0;
		end
	end

	assign load = accept && (!cfg.ok || emit);

	// top row of a pair writes pair sums, or the lone pixel of an odd last column
	assign mem_we    = accept && cfg.ok && paired && !r_odd && (c_odd || last_col);
	assign mem_addr  = col_q[ihdb_pkg::COL_W-1:1];
	assign mem_wdata = c_odd ? ({1'b0, held_q} + {1'b0, pixel_in}) : {1'b0, pixel_in};
	assign mem_re    = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			held_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept && cfg.ok) begin
			if (!c_odd && (paired || cfg.extra_row))
				held_q <= pixel_in;
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 16'd1;
			end else begin
				col_q <= col_q + 12'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_s1 <= 1'b0;
		else if (in_ready)
			s1_valid_s1 <= load;
	end

	always_ff @(posedge clk) begin
		if (load)
			s1_s1 <= nxt;
	end

	assign s1_valid = s1_valid_s1;
	assign s1       = s1_s1;

`ifndef SYNTHESIS
	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.ok |-> ({1'b0, col_q} < cfg.source_width))
		else $error("column counter beyond source width");
	a_no_write_on_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && load))
		else $error("line store write and result in the same item");
	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && !take) |=> (s1_valid_s1 && $stable(s1_s1)))
		else $error("s1 item lost under stall");
`endif

endmodule

`default_nettype wire

// ===== rtl/ihdb_out.sv =====
// Averaging arithmetic and the output register.
// Depends on ihdb_pkg; takes line store read data alongside the s1 item.
`default_nettype none

module ihdb_out (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s1_valid,
	input  wire ihdb_pkg::s1_t                 s1,
	input  wire logic [ihdb_pkg::SUM_W-1:0]    line_rd,
	output logic                               take,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [ihdb_pkg::PIX_W-1:0]         pixel_out,
	output logic                               status,
	output logic                               row_end,
	output logic                               frame_end
);

	logic                       valid_q;
	logic [ihdb_pkg::PIX_W-1:0] pix_q;
	logic                       status_q, row_end_q, frame_end_q;
	logic [ihdb_pkg::PIX_W+1:0] sum;
	logic [ihdb_pkg::PIX_W-1:0] avg;

	assign take = !valid_q || out_ready;

	always_comb begin
		sum = '0;
		avg = '0;
		case (s1.kind)
			ihdb_pkg::KIND_QUAD: begin
				sum = {1'b0, line_rd} + {2'b0, s1.held} + {2'b0, s1.pixel} + 10'd2;
				avg = sum[ihdb_pkg::PIX_W+1:2];
			end
			ihdb_pkg::KIND_VERT: begin
				sum = {1'b0, line_rd} + {2'b0, s1.pixel} + 10'd1;
				avg = sum[ihdb_pkg::PIX_W:1];
			end
			ihdb_pkg::KIND_HORZ: begin
				sum = {2'b0, s1.held} + {2'b0, s1.pixel} + 10'd1;
				avg = sum[ihdb_pkg::PIX_W:1];
			end
			default: avg = s1.pixel;
		endcase
		if (s1.err)
			avg = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (take)
			valid_q <= s1_valid;
	end

	always_ff @(posedge clk) begin
		if (take && s1_valid) begin
			pix_q       <= avg;
			status_q    <= s1.err;
			row_end_q   <= s1.row_end;
			frame_end_q <= s1.frame_end;
		end
	end

	assign out_valid = valid_q;
	assign pixel_out = pix_q;
	assign status    = status_q;
	assign row_end   = row_end_q;
	assign frame_end = frame_end_q;

endmodule

`default_nettype wire

// ===== tb/tb_image_half_downscale_box_unit.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the 2x2 box downscaler (image_half_downscale_box_unit).
// Needs ihdb_pkg and the block's RTL. A directed table comes first, then random frames
// and a few large sizes, all scored against a cycle-free prediction of the output pixels.
module tb_image_half_downscale_box_unit;

	localparam int DRAIN_WAIT      = 8;
	localparam int RX_HOLD_CYCLES  = 300;
	localparam int WATCHDOG_CYCLES = 2000;
	localparam int RANDOM_ITEMS    = 500;
	localparam int MAX_REPORTS     = 30;

	localparam logic [ihdb_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd4;
	localparam logic [ihdb_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;
	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_RANGE_ERR = 1'b1;

	typedef struct packed {
		logic [ihdb_pkg::PIX_W-1:0] pix;
		logic                       status;
		logic                       row_end;
		logic                       frame_end;
	} out_item_t;

	localparam out_item_t RANGE_ERR_ITEM = '{8'd0, STATUS_RANGE_ERR, 1'b0, 1'b0};

	typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_EXP} row_kind_t;
	typedef enum {FLOW_FULL, FLOW_TX_GAPS, FLOW_RX_STALLS, FLOW_BOTH} flow_t;
	typedef enum {PRESS_NONE, PRESS_RX_HOLD, PRESS_TX_PAUSE} press_t;

	typedef struct packed {
		row_kind_t                   kind;
		logic [ihdb_pkg::IDX_W-1:0]  idx;
		logic [ihdb_pkg::DATA_W-1:0] data;
		out_item_t                   want;
	} dir_row_t;

	// DUT signals
	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [ihdb_pkg::IDX_W-1:0]  cfg_index = '0;
	logic [ihdb_pkg::DATA_W-1:0] cfg_data = '0;
	logic                        in_valid = 1'b0;
	logic                        in_ready;
	logic [ihdb_pkg::PIX_W-1:0]  pixel_in = '0;
	logic                        out_valid;
	logic                        out_ready = 1'b0;
	logic [ihdb_pkg::PIX_W-1:0]  pixel_out;
	logic                        status;
	logic                        row_end;
	logic                        frame_end;

	image_half_downscale_box_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.status    (status),
		.row_end   (row_end),
		.frame_end (frame_end)
	);

	always #5 clk = ~clk;

	// predicted block state
	logic [ihdb_pkg::SRCW_W-1:0] src_w = 13'd2;
	logic [ihdb_pkg::SRCH_W-1:0] src_h = 16'd2;
	logic [ihdb_pkg::TGTW_W-1:0] tgt_w = 12'd1;
	logic [ihdb_pkg::TGTH_W-1:0] tgt_h = 16'd1;
	logic [ihdb_pkg::SUM_W-1:0]  line_sums [0:ihdb_pkg::LINE_DEPTH-1];
	logic [ihdb_pkg::PIX_W-1:0]  held = '0;
	int unsigned                 src_col = 0;
	int unsigned                 src_row = 0;

	out_item_t expected_pixels [$];

	int  mismatches = 0;
	int  pixels_sent = 0;
	int  results_seen = 0;
	int  range_errors = 0;
	int  cfg_writes = 0;
	int  phases = 0;
	int  tx_gap_pct = 0;
	int  rx_stall_pct = 0;
	int  hold_asks = 0;
	int  hold_seen = 0;
	int  hold_left = 0;
	int  idle_cycles = 0;
	out_item_t mon_want, mon_seen;

	dir_row_t directed_rows [32] = '{
		// reset sizes: 2x2 -> 1x1
		'{ROW_PIX,     '0, 16'd255, '0},
		'{ROW_PIX,     '0, 16'd255, '0},
		'{ROW_PIX,     '0, 16'd255, '0},
		'{ROW_PIX_EXP, '0, 16'd255, '{8'd255, STATUS_OK, 1'b1, 1'b1}},
		'{ROW_CFG, ihdb_pkg::REG_SOURCE_WIDTH, 16'd0, '0},
		'{ROW_PIX_EXP, '0, 16'h005a, RANGE_ERR_ITEM},
		// 3x3 -> 2x2: quad, odd column, odd row and the corner
		'{ROW_CFG, ihdb_pkg::REG_SOURCE_WIDTH,  16'd3, '0},
		'{ROW_CFG, ihdb_pkg::REG_TARGET_WIDTH,  16'd2, '0},
		'{ROW_CFG, ihdb_pkg::REG_SOURCE_HEIGHT, 16'd3, '0},
		'{ROW_CFG, ihdb_pkg::REG_TARGET_HEIGHT, 16'd2, '0},
		'{ROW_PIX, '0, 16'd0,   '0},
		'{ROW_PIX, '0, 16'd255, '0},
		'{ROW_PIX, '0, 16'd1,   '0},
		'{ROW_PIX, '0, 16'd254, '0},
		'{ROW_PIX, '0, 16'd2,   '0},
		'{ROW_PIX, '0, 16'd253, '0},
		'{ROW_PIX, '0, 16'd255, '0},
		'{ROW_PIX, '0, 16'd0,   '0},
		'{ROW_PIX, '0, 16'd255, '0},
		// 1x1 -> 0x0 gives nothing
		'{ROW_CFG, ihdb_pkg::REG_SOURCE_WIDTH,  16'd1, '0},
		'{ROW_CFG, ihdb_pkg::REG_SOURCE_HEIGHT, 16'd1, '0},
		'{ROW_CFG, ihdb_pkg::REG_TARGET_WIDTH,  16'd0, '0},
		'{ROW_CFG, ihdb_pkg::REG_TARGET_HEIGHT, 16'd0, '0},
		'{ROW_PIX, '0, 16'd77, '0},
		// 1x1 -> 1x1 passes the pixel through
		'{ROW_CFG, ihdb_pkg::REG_TARGET_WIDTH,  16'd1, '0},
		'{ROW_CFG, ihdb_pkg::REG_TARGET_HEIGHT, 16'd1, '0},
		'{ROW_PIX_EXP, '0, 16'd200, '{8'd200, STATUS_OK, 1'b1, 1'b1}},
		'{ROW_CFG, ihdb_pkg::REG_TARGET_WIDTH, 16'd2, '0},
		'{ROW_PIX_EXP, '0, 16'd255, RANGE_ERR_ITEM},
		// all-ones data masks to 8191: too wide
		'{ROW_CFG, ihdb_pkg::REG_SOURCE_WIDTH, 16'hffff, '0},
		'{ROW_CFG, REG_SPARE_HI,               16'h0000, '0},
		'{ROW_PIX_EXP, '0, 16'd0, RANGE_ERR_ITEM}
	};

	function automatic bit size_ok(input int unsigned src, input int unsigned dst);
		int unsigned half;
		half = src / 2;
		return (dst == half) || (src[0] && dst == half + 1);
	endfunction

	function automatic void latch_size_reg(input logic [ihdb_pkg::IDX_W-1:0] idx,
			input logic [ihdb_pkg::DATA_W-1:0] data);
		case (idx)
			ihdb_pkg::REG_SOURCE_WIDTH:  src_w = data[ihdb_pkg::SRCW_W-1:0];
			ihdb_pkg::REG_SOURCE_HEIGHT: src_h = data[ihdb_pkg::SRCH_W-1:0];
			ihdb_pkg::REG_TARGET_WIDTH:  tgt_w = data[ihdb_pkg::TGTW_W-1:0];
			ihdb_pkg::REG_TARGET_HEIGHT: tgt_h = data[ihdb_pkg::TGTH_W-1:0];
			default: return;
		endcase
		src_col = 0;
		src_row = 0;
	endfunction

	// advances the predicted state by one source pixel; returns 1 if it yields an output pixel
	function automatic bit box_average_step(input logic [ihdb_pkg::PIX_W-1:0] p,
			output out_item_t res);
		int unsigned sw, sh, tw, th, c, r, idx, orow, sum;
		bit last_col, extra_col, extra_row, got;
		sw = src_w; sh = src_h; tw = tgt_w; th = tgt_h;
		c = src_col; r = src_row;
		idx = c / 2; orow = r / 2;
		res = RANGE_ERR_ITEM;
		if (sw == 0 || sh == 0 || sw > ihdb_pkg::MAX_WIDTH ||
				!size_ok(sw, tw) || !size_ok(sh, th))
			return 1'b1;
		last_col = (c + 1 >= sw);
		extra_col = sw[0] && tw == sw / 2 + 1;
		extra_row = sh[0] && th == sh / 2 + 1;
		got = 1'b0;
		sum = 0;
		if (r < (sh & ~32'd1)) begin
			if (!r[0]) begin
				if (!c[0]) begin
					held = p;
					if (last_col)
						line_sums[idx] = {1'b0, p};
				end else begin
					line_sums[idx] = held + p;
				end
			end else if (!c[0]) begin
				held = p;
				if (last_col && extra_col) begin
					sum = (int'(line_sums[idx]) + int'(p) + 1) >> 1;
					got = 1'b1;
				end
			end else begin
				sum = (int'(line_sums[idx]) + int'(held) + int'(p) + 2) >> 2;
				got = 1'b1;
			end
		end else if (extra_row) begin
			if (!c[0]) begin
				held = p;
				if (last_col && extra_col) begin
					sum = p;
					got = 1'b1;
				end
			end else begin
				sum = (int'(held) + int'(p) + 1) >> 1;
				got = 1'b1;
			end
		end
		if (got) begin
			res.pix = sum[ihdb_pkg::PIX_W-1:0];
			res.status = STATUS_OK;
			res.row_end = (idx + 1 == tw);
			res.frame_end = res.row_end && (orow + 1 == th);
		end
		if (last_col) begin
			src_col = 0;
			src_row = (r + 1 >= sh) ? 0 : r + 1;
		end else begin
			src_col = c + 1;
		end
		return got;
	endfunction

	function automatic logic [ihdb_pkg::PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			default: return 8'($urandom);
		endcase
	endfunction

	// stop sending, wait for every predicted pixel, then let the pipe settle
	task automatic drain_block();
		if (in_valid)
			in_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_reg(input logic [ihdb_pkg::IDX_W-1:0] idx,
			input logic [ihdb_pkg::DATA_W-1:0] data);
		if (!cfg_valid)
			drain_block();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		latch_size_reg(idx, data);
		cfg_writes++;
	endtask

	// leaves in_valid high after the item; the next call or drain_block decides what follows
	task automatic send_pixel(input logic [ihdb_pkg::PIX_W-1:0] p, input bit typed,
			input out_item_t want);
		out_item_t pred;
		if (cfg_valid)
			cfg_valid <= 1'b0;
		if (tx_gap_pct != 0) begin
			while ($urandom_range(0, 99) < tx_gap_pct) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		pixel_in <= p;
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
		if (box_average_step(p, pred) && !typed)
			expected_pixels.push_back(pred);
		if (typed)
			expected_pixels.push_back(want);
	endtask

	task automatic run_phase(input int sw, input int sh, input int tw, input int th,
			input int n, input flow_t flow, input press_t press, input int pause_at);
		logic [ihdb_pkg::IDX_W-1:0]  regs [4];
		logic [ihdb_pkg::DATA_W-1:0] vals [4];
		int start, k;
		regs = '{ihdb_pkg::REG_SOURCE_WIDTH, ihdb_pkg::REG_SOURCE_HEIGHT,
			ihdb_pkg::REG_TARGET_WIDTH, ihdb_pkg::REG_TARGET_HEIGHT};
		// unused upper data bits get junk now and then
		vals[0] = {$urandom_range(0, 1) ? 3'($urandom) : 3'b000, 13'(sw)};
		vals[1] = 16'(sh);
		vals[2] = {$urandom_range(0, 1) ? 4'($urandom) : 4'b0000, 12'(tw)};
		vals[3] = 16'(th);
		start = $urandom_range(0, 3);
		for (k = 0; k < 4; k++)
			set_reg(regs[(start + k) % 4], vals[(start + k) % 4]);
		if ($urandom_range(0, 4) == 0)
			set_reg(3'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));
		case (flow)
			FLOW_FULL:      begin tx_gap_pct = 0;  rx_stall_pct <= 0;  end
			FLOW_TX_GAPS:   begin tx_gap_pct = 45; rx_stall_pct <= 0;  end
			FLOW_RX_STALLS: begin tx_gap_pct = 0;  rx_stall_pct <= 45; end
			default:        begin tx_gap_pct = 20; rx_stall_pct <= 20; end
		endcase
		if (press == PRESS_RX_HOLD)
			hold_asks <= hold_asks + 1;
		for (k = 0; k < n; k++) begin
			if (press == PRESS_TX_PAUSE && k == pause_at)
				drain_block();
			send_pixel(rand_pixel(), 1'b0, '0);
		end
		phases++;
	endtask

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_asks != hold_seen) begin
			hold_seen <= hold_asks;
			hold_left <= RX_HOLD_CYCLES;
			out_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			mon_seen = '{pixel_out, status, row_end, frame_end};
			results_seen++;
			if (status === STATUS_RANGE_ERR)
				range_errors++;
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: expected none, got %0d/%0b/%0b/%0b",
						$time, mon_seen.pix, mon_seen.status, mon_seen.row_end,
						mon_seen.frame_end);
			end else begin
				mon_want = expected_pixels.pop_front();
				if (mon_seen.pix !== mon_want.pix || mon_seen.status !== mon_want.status ||
						mon_seen.row_end !== mon_want.row_end ||
						mon_seen.frame_end !== mon_want.frame_end) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: expected %0d/%0b/%0b/%0b, got %0d/%0b/%0b/%0b",
							$time, mon_want.pix, mon_want.status, mon_want.row_end,
							mon_want.frame_end, mon_seen.pix, mon_seen.status,
							mon_seen.row_end, mon_seen.frame_end);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_CYCLES) begin
			$display("%0t: watchdog: no handshake for %0d cycles, %0d items still due",
				$time, idle_cycles, expected_pixels.size());
			$display("CHECK FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		dir_row_t entry;
		int sw, sh, tw, th, n, phase_no, random_sent;
		flow_t flow;
		press_t press;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(directed_rows); i++) begin
			entry = directed_rows[i];
			if (entry.kind == ROW_CFG)
				set_reg(entry.idx, entry.data);
			else
				send_pixel(entry.data[ihdb_pkg::PIX_W-1:0], entry.kind == ROW_PIX_EXP,
					entry.want);
		end

		phase_no = 0;
		random_sent = pixels_sent;
		while (pixels_sent - random_sent < RANDOM_ITEMS) begin
			flow = flow_t'(phase_no % 4);
			press = PRESS_NONE;
			sw = $urandom_range(1, 12);
			sh = $urandom_range(1, 10);
			tw = sw / 2 + (sw % 2 == 1 ? $urandom_range(0, 1) : 0);
			th = sh / 2 + (sh % 2 == 1 ? $urandom_range(0, 1) : 0);
			n = sw * sh * $urandom_range(1, 3);
			if ($urandom_range(0, 3) == 0)
				n = $urandom_range(1, n);
			if (phase_no == 2 || phase_no == 3) begin
				// back-pressure phases: a long receiver hold, then a sender pause mid-frame
				sw = 10; sh = 8; tw = 5; th = 4; n = 160;
				flow = FLOW_FULL;
				press = (phase_no == 2) ? PRESS_RX_HOLD : PRESS_TX_PAUSE;
			end else if ($urandom_range(0, 99) < 18) begin
				n = $urandom_range(4, 16);
				case ($urandom_range(0, 5))
					0: sw = 0;
					1: sh = 0;
					2: sw = $urandom_range(ihdb_pkg::MAX_WIDTH + 1, 8191);
					3: tw = sw / 2 + 2 + $urandom_range(0, 3);
					4: begin
						sw = 2 * $urandom_range(1, 6);
						tw = sw / 2 + 1;
					end
					default: th = sh / 2 + 2;
				endcase
			end
			run_phase(sw, sh, tw, th, n, flow, press, 100);
			phase_no++;
		end

		// largest sizes: start of the widest rows, then the tallest image
		run_phase(ihdb_pkg::MAX_WIDTH, 2, ihdb_pkg::MAX_WIDTH / 2, 1, 60, FLOW_BOTH,
			PRESS_NONE, 0);
		run_phase(ihdb_pkg::MAX_WIDTH - 1, 3, ihdb_pkg::MAX_WIDTH / 2, 2, 60,
			FLOW_RX_STALLS, PRESS_NONE, 0);
		run_phase(1, 65535, 1, 32768, 200, FLOW_TX_GAPS, PRESS_NONE, 0);
		run_phase(1, 65535, 0, 32767, 20, FLOW_FULL, PRESS_NONE, 0);

		drain_block();
		$display("Run: %0d pixels in %0d phases, %0d register writes, all four flow patterns.",
			pixels_sent, phases, cfg_writes);
		$display("Scored %0d output items (%0d range errors), %0d mismatches.",
			results_seen, range_errors, mismatches);
		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== image_half_downscale_box_unit.f =====
rtl/ihdb_pkg.sv
rtl/ihdb_cfg.sv
rtl/ihdb_line_mem.sv
rtl/ihdb_front.sv
rtl/ihdb_out.sv
rtl/image_half_downscale_box_unit.sv
tb/tb_image_half_downscale_box_unit.sv
